// ===== hdl/hsi_pkg.sv =====
// Package for the RGB to HSI pixel converter: pipeline payload type and hue boundary table.
package hsi_pkg;

    // Pi in unsigned Q2.30, and one in Q2.30.
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // floor(s / 3) is taken as (s * 683) >> 11, exact for sums up to 765.
    localparam logic [9:0] INV3_Q11 = 10'd683;

    // Hue code given to a gray pixel, which stands for an angle of 90 degrees.
    localparam logic [7:0] GRAY_HUE = 8'd63;

    // Upper end of the reflected hue code, used when blue exceeds green.
    localparam logic [7:0] HUE_REFLECT = 8'd254;

    // Number of cells in the chain: one per quotient bit of the saturation division.
    localparam int unsigned NUM_CELLS = 8;

    typedef logic [30:0] t_c2_table [0:127];

    // Squared cosine of the reduced angle m * pi / 255 in Q2.30, from a truncated series.
    function automatic logic [30:0] cos_sq_q30(input logic [7:0] m);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        sq;
        logic               done;
        if (m == 8'd85) begin
            return 31'(ONE_Q30 >> 2);
        end
        x    = (64'(m) * PI_Q30) / 64'd255;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        done = 1'b0;
        for (int n = 1; n <= 24; n++) begin
            if (!done) begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (term == 64'd0) begin
                    done = 1'b1;
                end else if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        sq = (64'(sum) * 64'(sum)) >> 30;
        return 31'(sq);
    endfunction

    // Squared cosine of every boundary angle k * 360 / 255 degrees, k = 0..127.
    function automatic t_c2_table build_c2_table();
        t_c2_table tab;
        for (int k = 0; k < 128; k++) begin
            if (k <= 63) begin
                tab[k] = cos_sq_q30(8'(2 * k));
            end else begin
                tab[k] = cos_sq_q30(8'(255 - 2 * k));
            end
        end
        return tab;
    endfunction

    localparam t_c2_table C2_TABLE = build_c2_table();

    // Payload that travels from cell to cell.
    typedef struct packed {
        logic        valid;
        logic [17:0] rem;      // running remainder of 255 * (s - 3 * min)
        logic [16:0] dsh;      // divisor (pixel sum) aligned to the current quotient bit
        logic [7:0]  quo;      // saturation quotient bits so far
        logic [17:0] xsq;      // square of 2r - g - b
        logic [17:0] f;        // 4 * ((r-g)^2 + (r-b)(g-b))
        logic        xpos;     // 2r - g - b is positive
        logic        strict;   // blue exceeds green: compare with a strict bound
        logic [6:0]  idx;      // hue boundary index found so far
        logic [6:0]  probe;    // boundary index bit tried in this cell
        logic        gray;
        logic        black;
        logic [7:0]  inten;
    } t_cell_data;

endpackage

// ===== hdl/hsi_prep.sv =====
// Input stage: sums, minimum, intensity and the operands of the hue and saturation cells.
module hsi_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_valid,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    output hsi_pkg::t_cell_data o_data
);
    import hsi_pkg::*;

    logic [9:0]         w_sum;
    logic [7:0]         w_min;
    logic [9:0]         w_spread;
    logic [19:0]        w_inten_prod;
    logic signed [10:0] w_x;
    logic [8:0]         w_xabs;
    logic signed [9:0]  w_rg;
    logic signed [9:0]  w_rb;
    logic signed [9:0]  w_gb;
    logic signed [20:0] w_pq;
    t_cell_data         n_data;
    t_cell_data         r_data;
    logic               r_valid;

    always_comb begin
        w_sum = 10'(i_red) + 10'(i_green) + 10'(i_blue);
        w_min = i_red;
        if (i_green < w_min) begin
            w_min = i_green;
        end
        if (i_blue < w_min) begin
            w_min = i_blue;
        end
        w_spread     = w_sum - 10'(3 * 10'(w_min));
        w_inten_prod = 20'(w_sum) * 20'(INV3_Q11);
        w_x    = $signed({2'b00, i_red, 1'b0}) - $signed({3'b000, i_green})
                 - $signed({3'b000, i_blue});
        w_xabs = w_x[10] ? 9'(-w_x) : 9'(w_x);
        w_rg   = $signed({2'b00, i_red})   - $signed({2'b00, i_green});
        w_rb   = $signed({2'b00, i_red})   - $signed({2'b00, i_blue});
        w_gb   = $signed({2'b00, i_green}) - $signed({2'b00, i_blue});
        w_pq   = 21'(w_rg * w_rg) + 21'(w_rb * w_gb);

        n_data        = '0;
        n_data.valid  = i_valid;
        n_data.rem    = {w_spread, 8'b0} - 18'(w_spread);
        n_data.dsh    = {w_sum, 7'b0};
        n_data.quo    = '0;
        n_data.xsq    = 18'(w_xabs) * 18'(w_xabs);
        n_data.f      = {w_pq[15:0], 2'b00};
        n_data.xpos   = !w_x[10] && (w_x != '0);
        n_data.strict = i_blue > i_green;
        n_data.idx    = '0;
        n_data.probe  = 7'h40;
        n_data.gray   = (i_red == i_green) && (i_green == i_blue);
        n_data.black  = w_sum == '0;
        n_data.inten  = w_inten_prod[18:11];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= n_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        o_data       = r_data;
        o_data.valid = r_valid;
    end

endmodule

// ===== hdl/hsi_cell.sv =====
// One cell of the chain: a restoring division step and a binary search step on the hue boundary.
module hsi_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  hsi_pkg::t_cell_data i_data,
    output hsi_pkg::t_cell_data o_data
);
    import hsi_pkg::*;

    logic [6:0]  w_cand;
    logic [30:0] w_c2;
    logic [47:0] w_lhs;
    logic [48:0] w_rhs;
    logic        w_hit;
    logic        w_fits;
    t_cell_data  n_data;
    t_cell_data  r_data;
    logic        r_valid;

    always_comb begin
        // Division step.
        w_fits = i_data.rem >= 18'(i_data.dsh);

        // Search step: is the hue angle beyond boundary w_cand, or on it unless strict?
        w_cand = i_data.idx | i_data.probe;
        w_c2   = C2_TABLE[w_cand];
        w_lhs  = {i_data.xsq, 30'b0};
        w_rhs  = 49'(i_data.f) * 49'(w_c2);
        if (!w_cand[6]) begin
            if (!i_data.xpos) begin
                w_hit = 1'b1;
            end else if (i_data.strict) begin
                w_hit = 49'(w_lhs) < w_rhs;
            end else begin
                w_hit = 49'(w_lhs) <= w_rhs;
            end
        end else begin
            if (i_data.xpos) begin
                w_hit = 1'b0;
            end else if (i_data.strict) begin
                w_hit = 49'(w_lhs) > w_rhs;
            end else begin
                w_hit = 49'(w_lhs) >= w_rhs;
            end
        end

        n_data       = i_data;
        n_data.rem   = w_fits ? (i_data.rem - 18'(i_data.dsh)) : i_data.rem;
        n_data.dsh   = i_data.dsh >> 1;
        n_data.quo   = {i_data.quo[6:0], w_fits};
        n_data.idx   = w_hit ? w_cand : i_data.idx;
        n_data.probe = i_data.probe >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        o_data       = r_data;
        o_data.valid = r_valid;
    end

endmodule

// ===== hdl/rgb_to_hsi_pixel.sv =====
// Top level of the RGB to HSI pixel converter: input stage, chain of cells and result mapping.
//
// Usage
// The input channel takes one RGB pixel per transfer on i_red, i_green and i_blue,
// qualified by i_valid and held off by o_stall. The output channel gives one HSI
// result per pixel on o_hue_code, o_saturation_code and o_intensity_code, qualified
// by o_valid and held off by i_stall. Results leave in the order the pixels came in.
// A pixel is registered once in the input stage and once in each of the eight cells,
// and its result is then shown at the end of the chain, ready for an output transfer.
// Throughput is one pixel per cycle while the receiver does not stall; each cell holds a
// different pixel and performs one quotient bit of the saturation division, and the first
// seven cells each perform one step of the binary search over the 128 hue boundaries.
// When the receiver stalls while a result is shown, the whole chain holds, the result
// stays unchanged and o_stall rises in the same cycle; pixels flow again once the stall
// drops. A synchronous reset (i_rst_n low) empties the chain: all valid flags clear,
// no result is shown and the block is ready for a transfer in the next cycle.
// Gray pixels give hue code 63 and black pixels give saturation code 0.
module rgb_to_hsi_pixel (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_hue_code,
    output logic [7:0] o_saturation_code,
    output logic [7:0] o_intensity_code
);
    import hsi_pkg::*;

    t_cell_data w_chain [0:NUM_CELLS];
    logic       w_advance;

    // The chain moves whenever the result at its end is absent or being taken.
    assign w_advance = !(w_chain[NUM_CELLS].valid && i_stall);
    assign o_stall   = !w_advance;

    hsi_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_valid   (i_valid),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .o_data    (w_chain[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        hsi_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_data    (w_chain[g]),
            .o_data    (w_chain[g + 1])
        );
    end

    // The search gives the highest boundary the angle has reached. When blue exceeds
    // green the angle is reflected, and the lowest boundary is always passed then.
    always_comb begin
        o_valid          = w_chain[NUM_CELLS].valid;
        o_intensity_code = w_chain[NUM_CELLS].inten;
        if (w_chain[NUM_CELLS].gray) begin
            o_hue_code = GRAY_HUE;
        end else if (w_chain[NUM_CELLS].strict) begin
            o_hue_code = HUE_REFLECT - 8'(w_chain[NUM_CELLS].idx);
        end else begin
            o_hue_code = 8'(w_chain[NUM_CELLS].idx);
        end
        o_saturation_code = w_chain[NUM_CELLS].black ? 8'd0 : w_chain[NUM_CELLS].quo;
    end

    // The reflected hue never reaches the top code.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hue_code != 8'd255)
        else $error("hue code out of range");

    // A pixel taken in reaches the input stage on the next edge.
    a_prep_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> w_chain[0].valid)
        else $error("accepted pixel lost at input stage");

    // A gray pixel has no spread, so the division must give zero.
    a_gray_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && w_chain[NUM_CELLS].gray |-> o_saturation_code == 8'd0)
        else $error("gray pixel with non-zero saturation");

    // A held result keeps its payload inside the last cell.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(w_chain[NUM_CELLS]))
        else $error("last cell changed while stalled");

endmodule

// ===== tb/tb_rgb_to_hsi_pixel.sv =====
// Self-checking testbench for the RGB to HSI pixel converter.
module tb_rgb_to_hsi_pixel;

    // Q2.30 constants used by the hue predictor.
    localparam logic [63:0] PI_FIX  = 64'd3373259426;
    localparam logic [63:0] ONE_FIX = 64'd1073741824;
    localparam int unsigned RANDOM_PIXELS = 1850;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned DRAIN_CYCLES  = 30;

    typedef struct {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] inten;
    } t_hsi;

    // One row of the directed table. Where check_code is set, the expected codes are
    // typed in and are compared with the predictor as well.
    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       check_code;
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] inten;
    } t_pixel_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_red;
    logic [7:0] i_green;
    logic [7:0] i_blue;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_hue_code;
    logic [7:0] o_saturation_code;
    logic [7:0] o_intensity_code;

    rgb_to_hsi_pixel uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_red             (i_red),
        .i_green           (i_green),
        .i_blue            (i_blue),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_hue_code        (o_hue_code),
        .o_saturation_code (o_saturation_code),
        .o_intensity_code  (o_intensity_code)
    );

    // Expected HSI results, oldest first.
    t_hsi        pending_hsi[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic [30:0] cos_sq_tab [0:127];
    // While set, the receiver never stalls; the sender's own flag is local to the driver.
    logic        calm_receiver;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Squared cosine of m * pi / 255 in Q2.30, from the truncated series.
    function automatic logic [63:0] reduced_angle_cos_sq(input int unsigned m);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        if (m == 85) begin
            return ONE_FIX >> 2;
        end
        x    = (64'(m) * PI_FIX) / 64'd255;
        x2   = (x * x) >> 30;
        term = ONE_FIX;
        acc  = $signed(ONE_FIX);
        for (int n = 1; n <= 24; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (term == 0) begin
                break;
            end
            if (n % 2 == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > $signed(ONE_FIX)) begin
            acc = $signed(ONE_FIX);
        end
        return (64'(acc) * 64'(acc)) >> 30;
    endfunction

    // Whether the hue angle lies past boundary k (or on it, unless strict).
    function automatic logic angle_past_boundary(input int unsigned k,
                                                 input longint xv,
                                                 input logic [63:0] f,
                                                 input logic strict);
        logic        cos_pos;
        logic [63:0] mag;
        logic [63:0] lhs;
        logic [63:0] rhs;
        cos_pos = (k <= 63);
        mag     = (xv < 0) ? 64'(-xv) : 64'(xv);
        lhs     = (mag * mag) << 30;
        rhs     = f * 64'(cos_sq_tab[k]);
        if (cos_pos) begin
            if (xv <= 0) begin
                return 1'b1;
            end
            return strict ? (lhs < rhs) : (lhs <= rhs);
        end
        if (xv > 0) begin
            return 1'b0;
        end
        return strict ? (lhs > rhs) : (lhs >= rhs);
    endfunction

    function automatic t_hsi predict_hsi(input logic [7:0] r8, input logic [7:0] g8,
                                         input logic [7:0] b8);
        t_hsi        res;
        longint      r;
        longint      g;
        longint      b;
        longint      s;
        longint      mn;
        longint      xv;
        logic [63:0] f;
        int unsigned t_floor;
        int unsigned t_ceil;
        r  = r8;
        g  = g8;
        b  = b8;
        s  = r + g + b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        res.inten = 8'(s / 3);
        res.sat   = (s == 0) ? 8'd0 : 8'((255 * (s - 3 * mn)) / s);
        if (r == g && g == b) begin
            res.hue = 8'd63;
        end else begin
            xv      = 2 * r - g - b;
            f       = 64'(4 * ((r - g) * (r - g) + (r - b) * (g - b)));
            t_floor = 0;
            t_ceil  = 0;
            for (int unsigned k = 0; k <= 127; k++) begin
                if (k >= 1 && angle_past_boundary(k, xv, f, 1'b0)) t_floor++;
                if (angle_past_boundary(k, xv, f, 1'b1)) t_ceil++;
            end
            res.hue = (b > g) ? 8'(255 - t_ceil) : 8'(t_floor);
        end
        return res;
    endfunction

    // Cycle counter and timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rgb_to_hsi_pixel regression: fail");
            $finish;
        end
    end

    // Receiver: stalls at random unless calm_receiver is set, and compares every result
    // transfer with the oldest expectation. Outputs are sampled at the rising edge before anything changes.
    always @(posedge i_clk) begin
        t_hsi want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_hsi.size() == 0) begin
                    $display("%0t: unexpected result hue %0d sat %0d int %0d", $time,
                             o_hue_code, o_saturation_code, o_intensity_code);
                    error_count++;
                end else begin
                    want = pending_hsi.pop_front();
                    if (o_hue_code !== want.hue) begin
                        $display("%0t: hue expected %0d actual %0d", $time, want.hue,
                                 o_hue_code);
                        error_count++;
                    end
                    if (o_saturation_code !== want.sat) begin
                        $display("%0t: saturation expected %0d actual %0d", $time,
                                 want.sat, o_saturation_code);
                        error_count++;
                    end
                    if (o_intensity_code !== want.inten) begin
                        $display("%0t: intensity expected %0d actual %0d", $time,
                                 want.inten, o_intensity_code);
                        error_count++;
                    end
                end
            end
            i_stall <= calm_receiver ? 1'b0 : ($urandom_range(99) < 23);
        end
    end

    // Offers one pixel and waits for its transfer. Before the pixel goes out, the
    // sender may idle at random, unless idling is switched off.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic calm);
        while (!calm && $urandom_range(99) < 23) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        pending_hsi.insert(pending_hsi.size(), predict_hsi(r, g, b));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Random pixels; half of the draws are set near hue boundaries or on the special cases.
    function automatic logic [23:0] random_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int unsigned d;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(9))
            0: begin g = r; b = r; end
            1: b = g;
            2: g = r;
            3: begin d = $urandom_range(3); g = 8'(r + d); b = 8'(r - d); end
            4: begin r = 8'($urandom_range(7)); g = 8'($urandom_range(7));
                     b = 8'($urandom_range(7)); end
            default: ;
        endcase
        return {r, g, b};
    endfunction

    t_pixel_row directed_rows[$];

    initial begin
        logic [23:0] px;
        t_hsi        got;
        logic        calm;
        int unsigned waited;
        int unsigned table_errors;
        table_errors  = 0;
        calm_receiver = 1'b1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_red   = 8'd0;
        i_green = 8'd0;
        i_blue  = 8'd0;
        for (int k = 0; k < 128; k++) begin
            cos_sq_tab[k] = 31'(reduced_angle_cos_sq((k <= 63) ? 2 * k : 255 - 2 * k));
        end

        // Black, white, grays and red have typed-in codes; the other rows, other primaries included, go by predictor.
        directed_rows = '{
            '{8'd0,   8'd0,   8'd0,   1'b1, 8'd63, 8'd0,   8'd0},
            '{8'd255, 8'd255, 8'd255, 1'b1, 8'd63, 8'd0,   8'd255},
            '{8'd128, 8'd128, 8'd128, 1'b1, 8'd63, 8'd0,   8'd128},
            '{8'd1,   8'd1,   8'd1,   1'b1, 8'd63, 8'd0,   8'd1},
            '{8'd255, 8'd0,   8'd0,   1'b1, 8'd0,  8'd255, 8'd85},
            '{8'd0,   8'd255, 8'd0,   1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd0,   8'd0,   8'd255, 1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd255, 8'd255, 8'd0,   1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd0,   8'd255, 8'd255, 1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd255, 8'd0,   8'd255, 1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd1,   8'd0,   8'd0,   1'b1, 8'd0,  8'd255, 8'd0},
            '{8'd0,   8'd0,   8'd1,   1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd0,   8'd1,   8'd0,   1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd170, 8'd85,  8'd85,  1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd85,  8'd85,  8'd170, 1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd254, 8'd255, 8'd253, 1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd255, 8'd254, 8'd255, 1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd170, 8'd85,  8'd0,   1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd85,  8'd170, 8'd255, 1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd100, 8'd50,  8'd51,  1'b0, 8'd0,  8'd0,   8'd0},
            '{8'd100, 8'd51,  8'd50,  1'b0, 8'd0,  8'd0,   8'd0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].check_code) begin
                got = predict_hsi(directed_rows[i].r, directed_rows[i].g,
                                  directed_rows[i].b);
                if (got.hue !== directed_rows[i].hue || got.sat !== directed_rows[i].sat ||
                    got.inten !== directed_rows[i].inten) begin
                    $display("%0t: table row %0d expected %0d/%0d/%0d actual %0d/%0d/%0d",
                             $time, i, directed_rows[i].hue, directed_rows[i].sat,
                             directed_rows[i].inten, got.hue, got.sat, got.inten);
                    table_errors++;
                end
            end
            send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b, 1'b1);
        end

        // Random pixels. The first 200 run with no idling on either side; then both
        // sides idle at random. Halfway, the sender holds off until the chain drains.
        for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
            calm          = (n < 200);
            calm_receiver <= calm;
            if (n == RANDOM_PIXELS / 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_hsi.size() != 0) @(posedge i_clk);
            end
            px = random_pixel();
            send_pixel(px[23:16], px[15:8], px[7:0], calm);
        end
        i_valid <= 1'b0;

        waited = 0;
        while (pending_hsi.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && table_errors == 0 && pending_hsi.size() == 0) begin
            $display("rgb_to_hsi_pixel regression: pass");
        end else begin
            $display("rgb_to_hsi_pixel regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/hsi_pkg.sv
hdl/hsi_prep.sv
hdl/hsi_cell.sv
hdl/rgb_to_hsi_pixel.sv
tb/tb_rgb_to_hsi_pixel.sv
